### hw/rtl/track_species_classifier_assert.svh
// ----------------------------------------------------------------------------
// Track species classifier assertion macros
// Shorthand for clocked implication checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef TRACK_SPECIES_CLASSIFIER_ASSERT_SVH
`define TRACK_SPECIES_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define TSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define TSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

### hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Track species classifier package
// Shared widths, register codes, transaction types and lookup tables.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned LaneMax         = 4;
  localparam int unsigned SpeciesCountDef = 4;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CfgPriorPion     = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgPriorKaon     = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgPriorProton   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgPriorElectron = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgTpcCut        = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgTofCut        = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgEtaLow        = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgEtaHigh       = 3'd7;

  localparam logic [15:0]        PriorPionRst     = 16'd32768;
  localparam logic [15:0]        PriorKaonRst     = 16'd6554;
  localparam logic [15:0]        PriorProtonRst   = 16'd3277;
  localparam logic [15:0]        PriorElectronRst = 16'd1638;
  localparam logic [14:0]        TpcCutRst        = 15'd3072;
  localparam logic [14:0]        TofCutRst        = 15'd3072;
  localparam logic signed [15:0] EtaLowRst        = -16'sd6144;
  localparam logic signed [15:0] EtaHighRst       = 16'sd6144;

  typedef struct packed {
    logic signed [15:0] eta;
    logic signed [15:0] tpc_nsigma_pion;
    logic signed [15:0] tpc_nsigma_kaon;
    logic signed [15:0] tpc_nsigma_proton;
    logic signed [15:0] tpc_nsigma_electron;
    logic signed [15:0] tof_nsigma_pion;
    logic signed [15:0] tof_nsigma_kaon;
    logic signed [15:0] tof_nsigma_proton;
    logic signed [15:0] tof_nsigma_electron;
    logic               tof_present;
  } tsc_in_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] species;
    logic       confident;
    logic [3:0] tpc_pass_mask;
    logic [3:0] combined_pass_mask;
  } tsc_out_t;

  typedef struct packed {
    logic         accepted;
    logic [3:0]   tpc_mask;
    logic [3:0]   comb_mask;
  } tsc_side_t;

  // 65536 * exp(-k/16), k = 0..16
  function automatic logic [16:0] frac_tab(input logic [4:0] k);
    logic [16:0] t;
    case (k)
      5'd0:    t = 17'd65536;
      5'd1:    t = 17'd61565;
      5'd2:    t = 17'd57835;
      5'd3:    t = 17'd54331;
      5'd4:    t = 17'd51039;
      5'd5:    t = 17'd47947;
      5'd6:    t = 17'd45042;
      5'd7:    t = 17'd42313;
      5'd8:    t = 17'd39750;
      5'd9:    t = 17'd37341;
      5'd10:   t = 17'd35079;
      5'd11:   t = 17'd32954;
      5'd12:   t = 17'd30957;
      5'd13:   t = 17'd29081;
      5'd14:   t = 17'd27319;
      5'd15:   t = 17'd25664;
      5'd16:   t = 17'd24109;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

  // 65536 * exp(-n)
  function automatic logic [16:0] int_tab(input logic [3:0] n);
    logic [16:0] t;
    case (n)
      4'd0:    t = 17'd65536;
      4'd1:    t = 17'd24109;
      4'd2:    t = 17'd8869;
      4'd3:    t = 17'd3263;
      4'd4:    t = 17'd1200;
      4'd5:    t = 17'd442;
      4'd6:    t = 17'd162;
      4'd7:    t = 17'd60;
      4'd8:    t = 17'd22;
      4'd9:    t = 17'd8;
      4'd10:   t = 17'd3;
      4'd11:   t = 17'd1;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

  // magnitude; minus full scale maps to 32768
  function automatic logic [15:0] mag16(input logic [15:0] v);
    logic [15:0] m;
    m = v[15] ? (~v + 16'd1) : v;
    return m;
  endfunction

endpackage

### hw/rtl/tsc_lane.sv
// ----------------------------------------------------------------------------
// Track species classifier lane
// Six-stage weight pipeline for one species: chi2, exp(-chi2/2), prior.
// ----------------------------------------------------------------------------
module tsc_lane (
  input  logic        clk_i,
  input  logic [15:0] atpc_i,
  input  logic [15:0] atof_i,
  input  logic        tof_ok_i,
  input  logic [15:0] prior_i,
  output logic [31:0] w_o
);

  // stage 1: squares
  logic [31:0] sq_tpc_q, sq_tof_q;
  // stage 2: table lookup
  logic        zero2_q;
  logic [3:0]  n2_q;
  logic [16:0] tk2_q;
  logic [11:0] dk2_q;
  logic [16:0] r2_q;
  // stage 3: interpolation product
  logic        zero3_q;
  logic [3:0]  n3_q;
  logic [16:0] tk3_q;
  logic [28:0] prod3_q;
  // stage 4: fraction factor
  logic        zero4_q;
  logic [16:0] f4_q;
  logic [16:0] en4_q;
  // stage 5: likelihood
  logic [15:0] l5_q;
  // stage 6: weight
  logic [31:0] w6_q;

  logic [31:0] chi2_d;
  logic [16:0] dk_full_d;
  logic [28:0] prod_d;
  logic [33:0] lp_d;
  logic [15:0] l_d;

  assign chi2_d    = sq_tpc_q + sq_tof_q;
  assign dk_full_d = tsc_pkg::frac_tab({1'b0, chi2_d[20:17]})
                   - tsc_pkg::frac_tab({1'b0, chi2_d[20:17]} + 5'd1);
  assign prod_d    = 29'(dk2_q) * 29'(r2_q);
  assign lp_d      = 34'(f4_q) * 34'(en4_q);
  assign l_d       = zero4_q ? 16'd0 : ((|lp_d[33:32]) ? 16'hFFFF : lp_d[31:16]);

  always_ff @(posedge clk_i) begin
    sq_tpc_q <= 32'(atpc_i) * 32'(atpc_i);
    sq_tof_q <= tof_ok_i ? 32'(atof_i) * 32'(atof_i) : 32'd0;

    zero2_q  <= |chi2_d[31:25];
    n2_q     <= chi2_d[24:21];
    tk2_q    <= tsc_pkg::frac_tab({1'b0, chi2_d[20:17]});
    dk2_q    <= dk_full_d[11:0];
    r2_q     <= chi2_d[16:0];

    zero3_q  <= zero2_q;
    n3_q     <= n2_q;
    tk3_q    <= tk2_q;
    prod3_q  <= prod_d;

    zero4_q  <= zero3_q;
    f4_q     <= tk3_q - {5'd0, prod3_q[28:17]};
    en4_q    <= tsc_pkg::int_tab(n3_q);

    l5_q     <= l_d;

    w6_q     <= 32'(l5_q) * 32'(prior_i);
  end

  assign w_o = w6_q;

endmodule

### hw/rtl/track_species_classifier.sv
// ----------------------------------------------------------------------------
// Track species classifier
// Per-track Bayesian species selection with TPC and TOF cut masks.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_i and raise start_i for one cycle per track. busy_o stays
//   low, so a track is taken at every edge where start_i is high; one track
//   per cycle is sustained.
//   Output: done_o strobes for one cycle with out_o holding the result
//   transaction. Results come out in input order. The receiver cannot stall;
//   every result must be taken in the cycle it is shown. Each track passes
//   through the input register (magnitudes, eta window, cut masks), the
//   per-species weight pipeline (squares, exp table, interpolation multiply,
//   likelihood multiply, prior multiply), a two-level registered max/sum
//   tree and the output register.
//   Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
//   (priors, cuts, eta window); write only while no track is in flight.
//   Reset: rst_ni clears all tracks in flight and restores the register
//   defaults.
// ----------------------------------------------------------------------------
module track_species_classifier #(
  parameter int unsigned SPECIES_COUNT = tsc_pkg::SpeciesCountDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  tsc_pkg::tsc_in_t                    in_i,
  input  logic                                cfg_we_i,
  input  logic [tsc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tsc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output logic                                done_o,
  output tsc_pkg::tsc_out_t                   out_o
);

  localparam int unsigned Lanes =
    (SPECIES_COUNT < tsc_pkg::LaneMax) ? SPECIES_COUNT : tsc_pkg::LaneMax;
  localparam int unsigned SideDepth = 7;

  // configuration registers
  logic [15:0]        prior_q [tsc_pkg::LaneMax];
  logic [14:0]        tpc_cut_q, tof_cut_q;
  logic signed [15:0] eta_low_q, eta_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q[0] <= tsc_pkg::PriorPionRst;
      prior_q[1] <= tsc_pkg::PriorKaonRst;
      prior_q[2] <= tsc_pkg::PriorProtonRst;
      prior_q[3] <= tsc_pkg::PriorElectronRst;
      tpc_cut_q  <= tsc_pkg::TpcCutRst;
      tof_cut_q  <= tsc_pkg::TofCutRst;
      eta_low_q  <= tsc_pkg::EtaLowRst;
      eta_high_q <= tsc_pkg::EtaHighRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsc_pkg::CfgPriorPion:     prior_q[0] <= cfg_data_i;
        tsc_pkg::CfgPriorKaon:     prior_q[1] <= cfg_data_i;
        tsc_pkg::CfgPriorProton:   prior_q[2] <= cfg_data_i;
        tsc_pkg::CfgPriorElectron: prior_q[3] <= cfg_data_i;
        tsc_pkg::CfgTpcCut:        tpc_cut_q  <= cfg_data_i[14:0];
        tsc_pkg::CfgTofCut:        tof_cut_q  <= cfg_data_i[14:0];
        tsc_pkg::CfgEtaLow:        eta_low_q  <= cfg_data_i;
        tsc_pkg::CfgEtaHigh:       eta_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // stage 1: magnitudes, eta window, cut masks
  logic [15:0]        tpc_ns [tsc_pkg::LaneMax];
  logic [15:0]        tof_ns [tsc_pkg::LaneMax];
  logic [15:0]        atpc_d [tsc_pkg::LaneMax];
  logic [15:0]        atof_d [tsc_pkg::LaneMax];
  logic [3:0]         tpc_mask_d, comb_mask_d;
  logic               eta_ok_d;
  tsc_pkg::tsc_side_t side_d;

  assign tpc_ns[0] = in_i.tpc_nsigma_pion;
  assign tpc_ns[1] = in_i.tpc_nsigma_kaon;
  assign tpc_ns[2] = in_i.tpc_nsigma_proton;
  assign tpc_ns[3] = in_i.tpc_nsigma_electron;
  assign tof_ns[0] = in_i.tof_nsigma_pion;
  assign tof_ns[1] = in_i.tof_nsigma_kaon;
  assign tof_ns[2] = in_i.tof_nsigma_proton;
  assign tof_ns[3] = in_i.tof_nsigma_electron;

  for (genvar i = 0; i < tsc_pkg::LaneMax; i++) begin : g_mag
    assign atpc_d[i] = tsc_pkg::mag16(tpc_ns[i]);
    assign atof_d[i] = tsc_pkg::mag16(tof_ns[i]);
    if (i < Lanes) begin : g_on
      assign tpc_mask_d[i]  = atpc_d[i] < {1'b0, tpc_cut_q};
      assign comb_mask_d[i] = tpc_mask_d[i] & in_i.tof_present
                            & (atof_d[i] < {1'b0, tof_cut_q});
    end else begin : g_off
      assign tpc_mask_d[i]  = 1'b0;
      assign comb_mask_d[i] = 1'b0;
    end
  end

  assign eta_ok_d = !((in_i.eta < eta_low_q) || (in_i.eta > eta_high_q));

  always_comb begin
    side_d.accepted  = eta_ok_d;
    side_d.tpc_mask  = eta_ok_d ? tpc_mask_d : 4'd0;
    side_d.comb_mask = eta_ok_d ? comb_mask_d : 4'd0;
  end

  logic [15:0]        atpc_q [tsc_pkg::LaneMax];
  logic [15:0]        atof_q [tsc_pkg::LaneMax];
  logic               tof_ok_q;
  logic               v_q    [SideDepth];
  tsc_pkg::tsc_side_t side_q [SideDepth];

  always_ff @(posedge clk_i) begin
    atpc_q   <= atpc_d;
    atof_q   <= atof_d;
    tof_ok_q <= in_i.tof_present;
    side_q[0] <= side_d;
    for (int j = 1; j < SideDepth; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SideDepth; j++) begin
        v_q[j] <= 1'b0;
      end
    end else begin
      v_q[0] <= accept;
      for (int j = 1; j < SideDepth; j++) begin
        v_q[j] <= v_q[j-1];
      end
    end
  end

  // per-species weights, aligned with side_q[SideDepth-1]
  logic [31:0] w [tsc_pkg::LaneMax];

  for (genvar i = 0; i < tsc_pkg::LaneMax; i++) begin : g_lane
    if (i < Lanes) begin : g_on
      tsc_lane u_lane (
        .clk_i    (clk_i),
        .atpc_i   (atpc_q[i]),
        .atof_i   (atof_q[i]),
        .tof_ok_i (tof_ok_q),
        .prior_i  (prior_q[i]),
        .w_o      (w[i])
      );
    end else begin : g_off
      assign w[i] = 32'd0;
    end
  end

  // pair stage
  logic               pv_q;
  tsc_pkg::tsc_side_t pside_q;
  logic [32:0]        sum01_q, sum23_q;
  logic [31:0]        b01_q, b23_q;
  logic               i01_q, i23_q;

  always_ff @(posedge clk_i) begin
    pside_q <= side_q[SideDepth-1];
    sum01_q <= {1'b0, w[0]} + {1'b0, w[1]};
    sum23_q <= {1'b0, w[2]} + {1'b0, w[3]};
    i01_q   <= w[1] > w[0];
    i23_q   <= w[3] > w[2];
    b01_q   <= (w[1] > w[0]) ? w[1] : w[0];
    b23_q   <= (w[3] > w[2]) ? w[3] : w[2];
  end

  // final stage
  logic               fv_q;
  tsc_pkg::tsc_side_t fside_q;
  logic [33:0]        sum_q;
  logic [31:0]        best_q;
  logic [1:0]         species_q;

  always_ff @(posedge clk_i) begin
    fside_q   <= pside_q;
    sum_q     <= {1'b0, sum01_q} + {1'b0, sum23_q};
    best_q    <= (b23_q > b01_q) ? b23_q : b01_q;
    species_q <= (b23_q > b01_q) ? {1'b1, i23_q} : {1'b0, i01_q};
  end

  // output register
  tsc_pkg::tsc_out_t out_d, out_q;
  logic              done_q;

  always_comb begin
    out_d.accepted           = fside_q.accepted;
    out_d.species            = fside_q.accepted ? species_q : 2'd0;
    out_d.confident          = fside_q.accepted && (sum_q != 34'd0)
                             && ({1'b0, best_q, 1'b0} > sum_q);
    out_d.tpc_pass_mask      = fside_q.tpc_mask;
    out_d.combined_pass_mask = fside_q.comb_mask;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      fv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= v_q[SideDepth-1];
      fv_q   <= pv_q;
      done_q <= fv_q;
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

### hw/rtl/tsc_checker.sv
// ----------------------------------------------------------------------------
// Track species classifier checker
// Port-level checks on latency and result consistency, bound to the top.
// ----------------------------------------------------------------------------
`include "track_species_classifier_assert.svh"

module tsc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input tsc_pkg::tsc_out_t out_o
);

  `TSC_ASSERT_NEXT(a_accept_to_done, clk_i, rst_ni, start_i && !busy_o, ##9 done_o, "track produced no result")

  `TSC_ASSERT_IMP(a_done_from_accept, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 10), "result without a track")

  `TSC_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, done_o && !out_o.accepted, (out_o.species == 2'd0 && !out_o.confident && out_o.tpc_pass_mask == 4'd0 && out_o.combined_pass_mask == 4'd0), "rejected track has nonzero fields")

  `TSC_ASSERT_IMP(a_comb_subset, clk_i, rst_ni, done_o, ((out_o.combined_pass_mask & ~out_o.tpc_pass_mask) == 4'd0), "combined cut passed without TPC cut")

endmodule

bind track_species_classifier tsc_checker u_tsc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .out_o   (out_o)
);

### sim/track_species_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track species classifier testbench
// Sends track transactions through start/busy and checks every result against
// a local fixed-point model of the eta window, the per-species likelihood
// weights, the species pick, the confidence test and the cut masks. Runs a
// directed set first, then random phases under varied register settings.
// ----------------------------------------------------------------------------
module track_species_classifier_tb;
  import tsc_pkg::*;

  localparam int RESULT_LATENCY = 10;
  localparam int DRAIN_LIMIT    = 4 * RESULT_LATENCY + 32;
  localparam int NUM_REGS       = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_TRACKS   = 140;
  localparam int MAX_GAP        = 17;
  localparam int TIMEOUT_NS     = 400_000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  tsc_in_t                 in_i;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    done_o;
  tsc_out_t                out_o;

  longint exp_frac_lut [0:16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                  42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                  27319, 25664, 24109};
  longint exp_int_lut [0:15] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
                                 8, 3, 1, 0, 0, 0, 0};

  logic [15:0] reg_shadow [NUM_REGS];
  logic [15:0] cfg_next [NUM_REGS];
  tsc_out_t    pid_queue [$];
  int          error_count = 0;

  track_species_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .out_o      (out_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // exp(-chi2/2) in Q0.16, chi2 in Q12.20
  function automatic longint gauss_weight(input longint chi2);
    int     n;
    int     k;
    longint r;
    longint f;
    longint l;
    if (chi2 >= (longint'(32) << 20)) return 0;
    n = int'(chi2 >> 21) & 15;
    k = int'(chi2 >> 17) & 15;
    r = chi2 & 64'h1FFFF;
    f = exp_frac_lut[k] - (((exp_frac_lut[k] - exp_frac_lut[k + 1]) * r) >> 17);
    l = (f * exp_int_lut[n]) >> 16;
    return (l > 65535) ? 65535 : l;
  endfunction

  function automatic tsc_out_t identify_track(input tsc_in_t trk);
    logic signed [15:0] tpc [4];
    logic signed [15:0] tof [4];
    longint             prior [4];
    longint             chi2;
    longint             weight;
    longint             best;
    longint             total;
    int                 atpc;
    int                 atof;
    int                 tpc_cut;
    int                 tof_cut;
    int                 eta_lo;
    int                 eta_hi;
    int                 eta;
    tsc_out_t           res;
    res     = '0;
    eta_lo  = int'($signed(reg_shadow[CfgEtaLow]));
    eta_hi  = int'($signed(reg_shadow[CfgEtaHigh]));
    eta     = int'($signed(trk.eta));
    if (eta < eta_lo || eta > eta_hi) return res;
    tpc_cut = int'(reg_shadow[CfgTpcCut][14:0]);
    tof_cut = int'(reg_shadow[CfgTofCut][14:0]);
    prior[0] = reg_shadow[CfgPriorPion];
    prior[1] = reg_shadow[CfgPriorKaon];
    prior[2] = reg_shadow[CfgPriorProton];
    prior[3] = reg_shadow[CfgPriorElectron];
    tpc[0] = trk.tpc_nsigma_pion;
    tpc[1] = trk.tpc_nsigma_kaon;
    tpc[2] = trk.tpc_nsigma_proton;
    tpc[3] = trk.tpc_nsigma_electron;
    tof[0] = trk.tof_nsigma_pion;
    tof[1] = trk.tof_nsigma_kaon;
    tof[2] = trk.tof_nsigma_proton;
    tof[3] = trk.tof_nsigma_electron;
    best  = 0;
    total = 0;
    for (int i = 0; i < LaneMax; i++) begin
      atpc = (tpc[i] < 0) ? -int'(tpc[i]) : int'(tpc[i]);
      atof = (tof[i] < 0) ? -int'(tof[i]) : int'(tof[i]);
      chi2 = longint'(atpc) * atpc;
      if (trk.tof_present) chi2 += longint'(atof) * atof;
      weight = gauss_weight(chi2) * prior[i];
      total += weight;
      if (i == 0 || weight > best) begin
        best        = weight;
        res.species = 2'(i);
      end
      if (atpc < tpc_cut) begin
        res.tpc_pass_mask[i] = 1'b1;
        if (trk.tof_present && atof < tof_cut) res.combined_pass_mask[i] = 1'b1;
      end
    end
    res.accepted  = 1'b1;
    res.confident = (total > 0 && 2 * best > total);
    return res;
  endfunction

  function automatic tsc_in_t make_track(input int eta, input int tp, input int tk,
                                         input int tr, input int te, input int fp,
                                         input int fk, input int fr, input int fe,
                                         input bit tof_on);
    tsc_in_t t;
    t.eta                 = 16'(eta);
    t.tpc_nsigma_pion     = 16'(tp);
    t.tpc_nsigma_kaon     = 16'(tk);
    t.tpc_nsigma_proton   = 16'(tr);
    t.tpc_nsigma_electron = 16'(te);
    t.tof_nsigma_pion     = 16'(fp);
    t.tof_nsigma_kaon     = 16'(fk);
    t.tof_nsigma_proton   = 16'(fr);
    t.tof_nsigma_electron = 16'(fe);
    t.tof_present         = tof_on;
    return t;
  endfunction

  function automatic int unsigned sender_gap();
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [15:0] draw_nsigma(input int cut);
    int pick;
    int mag;
    pick = $urandom_range(0, 19);
    if (pick < 11) mag = $urandom_range(0, 4096);
    else if (pick < 14) mag = $urandom_range(0, 7000);
    else if (pick < 16) mag = cut + int'($urandom_range(0, 2)) - 1;
    else if (pick < 17) return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    else return 16'($urandom);
    if ($urandom_range(0, 1)) mag = -mag;
    return 16'(mag);
  endfunction

  function automatic logic [15:0] draw_eta();
    int lo;
    int hi;
    int pick;
    lo   = int'($signed(reg_shadow[CfgEtaLow]));
    hi   = int'($signed(reg_shadow[CfgEtaHigh]));
    pick = $urandom_range(0, 19);
    if (lo <= hi && pick < 14) return 16'(lo + int'($urandom_range(0, hi - lo)));
    case (pick)
      14:      return 16'(lo - 1);
      15:      return 16'(lo);
      16:      return 16'(hi);
      17:      return 16'(hi + 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tsc_in_t draw_track();
    tsc_in_t t;
    int      tcut;
    int      fcut;
    tcut                  = int'(reg_shadow[CfgTpcCut][14:0]);
    fcut                  = int'(reg_shadow[CfgTofCut][14:0]);
    t.eta                 = draw_eta();
    t.tpc_nsigma_pion     = draw_nsigma(tcut);
    t.tpc_nsigma_kaon     = draw_nsigma(tcut);
    t.tpc_nsigma_proton   = draw_nsigma(tcut);
    t.tpc_nsigma_electron = draw_nsigma(tcut);
    t.tof_nsigma_pion     = draw_nsigma(fcut);
    t.tof_nsigma_kaon     = draw_nsigma(fcut);
    t.tof_nsigma_proton   = draw_nsigma(fcut);
    t.tof_nsigma_electron = draw_nsigma(fcut);
    t.tof_present         = ($urandom_range(0, 3) != 0);
    return t;
  endfunction

  function automatic logic [15:0] draw_prior();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'd0;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] draw_cut();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(512, 6000));
  endfunction

  function automatic void draw_settings();
    int lo;
    int hi;
    int tmp;
    lo = int'($urandom_range(0, 65535)) - 32768;
    hi = int'($urandom_range(0, 65535)) - 32768;
    if (lo > hi && $urandom_range(0, 6) != 0) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    cfg_next[CfgPriorPion]     = draw_prior();
    cfg_next[CfgPriorKaon]     = draw_prior();
    cfg_next[CfgPriorProton]   = draw_prior();
    cfg_next[CfgPriorElectron] = draw_prior();
    cfg_next[CfgTpcCut]        = draw_cut();
    cfg_next[CfgTofCut]        = draw_cut();
    cfg_next[CfgEtaLow]        = 16'(lo);
    cfg_next[CfgEtaHigh]       = 16'(hi);
  endfunction

  function automatic void load_reset_settings();
    cfg_next[CfgPriorPion]     = PriorPionRst;
    cfg_next[CfgPriorKaon]     = PriorKaonRst;
    cfg_next[CfgPriorProton]   = PriorProtonRst;
    cfg_next[CfgPriorElectron] = PriorElectronRst;
    cfg_next[CfgTpcCut]        = 16'(TpcCutRst);
    cfg_next[CfgTofCut]        = 16'(TofCutRst);
    cfg_next[CfgEtaLow]        = EtaLowRst;
    cfg_next[CfgEtaHigh]       = EtaHighRst;
  endfunction

  function automatic void set_priors(input logic [15:0] p0, input logic [15:0] p1,
                                     input logic [15:0] p2, input logic [15:0] p3);
    cfg_next[CfgPriorPion]     = p0;
    cfg_next[CfgPriorKaon]     = p1;
    cfg_next[CfgPriorProton]   = p2;
    cfg_next[CfgPriorElectron] = p3;
  endfunction

  task automatic send_track(input tsc_in_t trk, input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= trk;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pid_queue.push_back(identify_track(trk));
  endtask

  task automatic drain_tracks();
    int waited = 0;
    start_i <= 1'b0;
    while (pid_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pid_queue.size() != 0) begin
      $error("%0d result transactions never arrived", pid_queue.size());
      error_count++;
      pid_queue.delete();
    end
  endtask

  // writes all registers from cfg_next; call only with nothing in flight
  task automatic apply_config();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxWidth'(i);
      cfg_data_i <= cfg_next[i];
      @(posedge clk_i);
      reg_shadow[i] = cfg_next[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_window_edges();
    send_track(make_track(-6144, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(6144, 1024, -1024, 2048, -2048, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(-6145, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(6145, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(-32768, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(32767, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
  endtask

  task automatic test_species_choice();
    send_track(make_track(0, 5000, 0, 4000, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    // all weights zero
    send_track(make_track(0, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 1'b1),
               sender_gap());
    send_track(make_track(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0),
               sender_gap());
    // chi2 just below and just above 32
    send_track(make_track(0, 5792, 5793, 5792, 5793, 0, 0, 0, 0, 1'b1), sender_gap());
    // TOF missing: TOF values must not count
    send_track(make_track(0, 1000, 0, 0, 0, -32768, 32767, -32768, 32767, 1'b0),
               sender_gap());
    send_track(make_track(0, 3071, -3072, -3071, 3072, -3071, 3071, 3072, -3072, 1'b1),
               sender_gap());
    send_track(make_track(100, 500, 500, 500, 500, 3000, 0, 2000, 0, 1'b1), sender_gap());
  endtask

  task automatic test_ties_and_priors();
    drain_tracks();
    cfg_next = reg_shadow;
    set_priors(16'd16384, 16'd16384, 16'd16384, 16'd16384);
    apply_config();
    send_track(make_track(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(0, 4096, 1000, -1000, 2048, 0, 0, 0, 0, 1'b1), sender_gap());
    drain_tracks();
    set_priors(16'd0, 16'd65535, 16'd32768, 16'd0);
    apply_config();
    send_track(make_track(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(0, 0, 4000, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    drain_tracks();
    set_priors(16'd0, 16'd0, 16'd0, 16'd0);
    apply_config();
    send_track(make_track(0, 0, 100, -200, 3000, 0, 0, 0, 0, 1'b1), sender_gap());
  endtask

  task automatic test_inverted_window();
    drain_tracks();
    load_reset_settings();
    cfg_next[CfgEtaLow]  = 16'd100;
    cfg_next[CfgEtaHigh] = -16'sd100;
    apply_config();
    send_track(make_track(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(-100, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
    send_track(make_track(100, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), sender_gap());
  endtask

  // cut registers are 15 bits wide; bit 15 of the write data is dropped
  task automatic test_register_width();
    drain_tracks();
    cfg_next[CfgTpcCut]  = 16'hFFFF;
    cfg_next[CfgTofCut]  = 16'hFFFF;
    cfg_next[CfgEtaLow]  = 16'h8000;
    cfg_next[CfgEtaHigh] = 16'h7FFF;
    apply_config();
    send_track(make_track(-32768, 32767, 32766, -32768, -32767, 32766, 32767, 0, -32767,
                          1'b1), sender_gap());
    send_track(make_track(32767, -32766, 0, 32766, 1, -32766, 0, 32767, -32768, 1'b1),
               sender_gap());
  endtask

  task automatic test_random_phases();
    bit burst;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_tracks();
      case (p)
        0: load_reset_settings();
        1: begin
          set_priors(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          cfg_next[CfgTpcCut]  = 16'hFFFF;
          cfg_next[CfgTofCut]  = 16'hFFFF;
          cfg_next[CfgEtaLow]  = 16'h8000;
          cfg_next[CfgEtaHigh] = 16'h7FFF;
        end
        2: begin
          set_priors(16'd0, 16'd0, 16'd0, 16'd0);
          cfg_next[CfgTpcCut]  = 16'd0;
          cfg_next[CfgTofCut]  = 16'd0;
          cfg_next[CfgEtaLow]  = 16'h8000;
          cfg_next[CfgEtaHigh] = 16'h8000;
        end
        default: draw_settings();
      endcase
      apply_config();
      burst = (p % 3 == 1);
      for (int n = 0; n < PHASE_TRACKS; n++) begin
        send_track(draw_track(), burst ? 0 : sender_gap());
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_pid
    tsc_out_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pid_queue.size() == 0) begin
        $error("result transaction with none pending: %p", out_o);
        error_count++;
      end else begin
        want = pid_queue.pop_front();
        check_field("accepted", 4'(want.accepted), 4'(out_o.accepted));
        check_field("species", 4'(want.species), 4'(out_o.species));
        check_field("confident", 4'(want.confident), 4'(out_o.confident));
        check_field("tpc_pass_mask", want.tpc_pass_mask, out_o.tpc_pass_mask);
        check_field("combined_pass_mask", want.combined_pass_mask,
                    out_o.combined_pass_mask);
      end
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    in_i       <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CfgPriorPion;
    cfg_data_i <= '0;
    load_reset_settings();
    reg_shadow = cfg_next;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_window_edges();
    test_species_choice();
    test_ties_and_priors();
    test_inverted_window();
    test_register_width();
    test_random_phases();

    drain_tracks();
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
    if (error_count == 0 && pid_queue.size() == 0) begin
      $display("track_species_classifier verification clean");
    end else begin
      $display("track_species_classifier verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("track_species_classifier verification failed");
    $finish;
  end

endmodule
